// File: rtl/core/pse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pse_pkg;

  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned DEPTH_W     = 5;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned OP_W        = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_DIVZ  = 2'd3
  } status_e;

  typedef enum logic [OP_W-1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_OPER = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_DECODE = 3'd1,
    S_READ   = 3'd2,
    S_DIV    = 3'd3,
    S_WRITE  = 3'd4,
    S_RESP   = 3'd5
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic    latch;
    logic    push;
    logic    rd;
    logic    alu;
    logic    div_start;
    logic    div_take;
    logic    pop_write;
    logic    set_status;
    status_e status;
    logic    emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    action_e action;
    op_e     op;
    logic    full;
    logic    lt2;
    logic    top_zero;
    logic    div_done;
    logic    out_busy;
  } stat_t;

endpackage

`default_nettype wire

// File: rtl/core/pse_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pse_in_if;
  logic                                valid;
  logic                                ready;
  logic                                action;
  logic signed [pse_pkg::DATA_W-1:0]   token_value;
  logic        [pse_pkg::OP_W-1:0]     operator_code;

  modport source (output valid, action, token_value, operator_code, input ready);
  modport sink   (input valid, action, token_value, operator_code, output ready);
endinterface

`default_nettype wire

// File: rtl/core/pse_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pse_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [pse_pkg::DATA_W-1:0]   top_value;
  logic signed [pse_pkg::DATA_W-1:0]   bottom_value;
  logic        [pse_pkg::DEPTH_W-1:0]  depth;
  logic        [pse_pkg::STATUS_W-1:0] status;

  modport source (output valid, top_value, bottom_value, depth, status, input ready);
  modport sink   (input valid, top_value, bottom_value, depth, status, output ready);
endinterface

`default_nettype wire

// File: rtl/core/pse_div.sv
`timescale 1ns / 1ps
`default_nettype none

// unsigned restoring divider, one quotient bit per cycle
module pse_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [pse_pkg::DATA_W-1:0]  dividend_i,
  input  wire logic [pse_pkg::DATA_W-1:0]  divisor_i,
  output logic                             done_o,
  output logic      [pse_pkg::DATA_W-1:0]  quotient_o
);

  localparam int unsigned W   = pse_pkg::DATA_W;
  localparam int unsigned CW  = $clog2(W + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  quo_q, quo_d;
  logic [W-1:0]  div_q, div_d;

  logic [W:0]    rem_shift;
  logic [W+1:0]  diff;

  always_comb begin
    rem_shift = {rem_q, quo_q[W-1]};
    diff      = {1'b0, rem_shift} - {2'b00, div_q};
    busy_d    = busy_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    div_d     = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(W);
      rem_d  = '0;
      quo_d  = dividend_i;
      div_d  = divisor_i;
    end else if (busy_q) begin
      // trial subtract, keep it when no borrow
      if (!diff[W+1]) begin
        rem_d = diff[W-1:0];
      end else begin
        rem_d = rem_shift[W-1:0];
      end
      quo_d = {quo_q[W-2:0], ~diff[W+1]};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// File: rtl/core/pse_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module pse_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire pse_pkg::stat_t   stat_i,
  output pse_pkg::cmd_t         cmd_o
);

  pse_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pse_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.status = pse_pkg::ST_OK;
    in_ready_o = 1'b0;
    unique case (state_q)
      pse_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = pse_pkg::S_DECODE;
        end
      end
      pse_pkg::S_DECODE: begin
        if (stat_i.action == pse_pkg::ACT_PUSH) begin
          if (stat_i.full) begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = pse_pkg::ST_OVER;
          end else begin
            cmd_o.push = 1'b1;
          end
          state_d = pse_pkg::S_RESP;
        end else if (stat_i.lt2) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = pse_pkg::ST_UNDER;
          state_d          = pse_pkg::S_RESP;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = pse_pkg::S_READ;
        end
      end
      pse_pkg::S_READ: begin
        if (stat_i.op == pse_pkg::OP_DIV) begin
          if (stat_i.top_zero) begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = pse_pkg::ST_DIVZ;
            state_d          = pse_pkg::S_RESP;
          end else begin
            cmd_o.div_start = 1'b1;
            state_d         = pse_pkg::S_DIV;
          end
        end else begin
          cmd_o.alu = 1'b1;
          state_d   = pse_pkg::S_WRITE;
        end
      end
      pse_pkg::S_DIV: begin
        if (stat_i.div_done) begin
          cmd_o.div_take = 1'b1;
          state_d        = pse_pkg::S_WRITE;
        end
      end
      pse_pkg::S_WRITE: begin
        cmd_o.pop_write = 1'b1;
        state_d         = pse_pkg::S_RESP;
      end
      pse_pkg::S_RESP: begin
        if (!stat_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = pse_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = pse_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/pse_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module pse_datapath #(
  parameter int unsigned StackDepth = pse_pkg::STACK_DEPTH
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire pse_pkg::cmd_t                      cmd_i,
  output pse_pkg::stat_t                          stat_o,
  input  wire logic                               action_i,
  input  wire logic signed [pse_pkg::DATA_W-1:0]  token_value_i,
  input  wire logic        [pse_pkg::OP_W-1:0]    operator_code_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic signed [pse_pkg::DATA_W-1:0]       top_value_o,
  output logic signed [pse_pkg::DATA_W-1:0]       bottom_value_o,
  output logic        [pse_pkg::DEPTH_W-1:0]      depth_o,
  output logic        [pse_pkg::STATUS_W-1:0]     status_o
);

  localparam int unsigned W   = pse_pkg::DATA_W;
  localparam int unsigned AW  = $clog2(StackDepth);
  localparam int unsigned CNT = $clog2(StackDepth + 1);

  logic [W-1:0] mem [StackDepth];

  logic [CNT-1:0]          count_q;
  logic [W-1:0]            top_q;
  logic [W-1:0]            bottom_q;
  logic [W-1:0]            rd_q;
  logic [W-1:0]            res_q;
  logic [W-1:0]            value_q;
  pse_pkg::action_e        action_q;
  pse_pkg::op_e            op_q;
  pse_pkg::status_e        status_q;
  logic                    neg_q;
  logic                    out_valid_q;
  logic [W-1:0]            out_top_q;
  logic [W-1:0]            out_bottom_q;
  logic [pse_pkg::DEPTH_W-1:0] out_depth_q;
  pse_pkg::status_e        out_status_q;

  logic [CNT-1:0] second_idx;
  logic [W-1:0]   alu_res;
  logic [W-1:0]   y_mag;
  logic [W-1:0]   x_mag;
  logic           div_done;
  logic [W-1:0]   quo;
  logic [W-1:0]   prod;

  assign second_idx = count_q - CNT'(2);
  assign prod       = W'(top_q * rd_q);

  always_comb begin
    unique case (op_q)
      pse_pkg::OP_ADD: alu_res = top_q + rd_q;
      pse_pkg::OP_SUB: alu_res = rd_q - top_q;
      pse_pkg::OP_MUL: alu_res = prod;
      default:         alu_res = '0;
    endcase
    y_mag = rd_q[W-1]  ? (~rd_q + W'(1))  : rd_q;
    x_mag = top_q[W-1] ? (~top_q + W'(1)) : top_q;
  end

  pse_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (y_mag),
    .divisor_i  (x_mag),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // stack memory, one write port and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[count_q[AW-1:0]] <= value_q;
    end else if (cmd_i.pop_write) begin
      mem[second_idx[AW-1:0]] <= res_q;
    end
    if (cmd_i.rd) begin
      rd_q <= mem[second_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      status_q    <= pse_pkg::ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.latch) begin
        status_q <= pse_pkg::ST_OK;
      end else if (cmd_i.set_status) begin
        status_q <= cmd_i.status;
      end
      if (cmd_i.push) begin
        count_q <= count_q + CNT'(1);
      end else if (cmd_i.pop_write) begin
        count_q <= count_q - CNT'(1);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      action_q <= pse_pkg::action_e'(action_i);
      op_q     <= pse_pkg::op_e'(operator_code_i);
      value_q  <= token_value_i;
    end
    if (cmd_i.div_start) begin
      neg_q <= rd_q[W-1] ^ top_q[W-1];
    end
    if (cmd_i.alu) begin
      res_q <= alu_res;
    end else if (cmd_i.div_take) begin
      res_q <= neg_q ? (~quo + W'(1)) : quo;
    end
    if (cmd_i.push) begin
      top_q <= value_q;
      if (count_q == '0) begin
        bottom_q <= value_q;
      end
    end else if (cmd_i.pop_write) begin
      top_q <= res_q;
      if (second_idx == '0) begin
        bottom_q <= res_q;
      end
    end
    if (cmd_i.emit) begin
      out_top_q    <= (count_q == '0) ? '0 : top_q;
      out_bottom_q <= (count_q == '0) ? '0 : bottom_q;
      out_depth_q  <= pse_pkg::DEPTH_W'(count_q);
      out_status_q <= status_q;
    end
  end

  always_comb begin
    stat_o.action   = action_q;
    stat_o.op       = op_q;
    stat_o.full     = (count_q == CNT'(StackDepth));
    stat_o.lt2      = (count_q < CNT'(2));
    stat_o.top_zero = (top_q == '0);
    stat_o.div_done = div_done;
    stat_o.out_busy = out_valid_q && !out_ready_i;
  end

  assign out_valid_o    = out_valid_q;
  assign top_value_o    = out_top_q;
  assign bottom_value_o = out_bottom_q;
  assign depth_o        = out_depth_q;
  assign status_o       = out_status_q;

endmodule

`default_nettype wire

// File: rtl/core/postfix_stack_evaluator.sv
// sequence: push, overflow and underflow go decode then respond; divide by zero
//   adds the operand read; add, subtract and multiply read, execute and write back;
//   divide reads, runs the 32-step divider loop and writes back; one token is taken
//   at a time, the next only after the result has entered the output register
// reset: asynchronous active-low rst_ni empties the stack and drops any
//   pending result; stack memory contents are left as they were
`timescale 1ns / 1ps
`default_nettype none

module postfix_stack_evaluator #(
  parameter int unsigned StackDepth = pse_pkg::STACK_DEPTH
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pse_in_if.sink     in_i,
  pse_out_if.source  out_o
);

  // command and status between sequencer and datapath
  pse_pkg::cmd_t  cmd;
  pse_pkg::stat_t stat;

  // sequencer: accept, decode, operand read, execute or divide, write back, respond
  pse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath: stack memory with cached top and bottom entries, alu,
  // iterative divider and the output register that decouples the result side
  pse_datapath #(
    .StackDepth (StackDepth)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .action_i        (in_i.action),
    .token_value_i   (in_i.token_value),
    .operator_code_i (in_i.operator_code),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .top_value_o     (out_o.top_value),
    .bottom_value_o  (out_o.bottom_value),
    .depth_o         (out_o.depth),
    .status_o        (out_o.status)
  );

endmodule

`default_nettype wire
